// File: rtl/ocp_pkg.sv
// ============================================================================
// ocp_pkg
// Shared types, constants and helpers of the fisheye point projection block.
// ============================================================================
package ocp_pkg;

    localparam int MAX_COEFS = 16;
    localparam int COEF_IDX_W = $clog2(MAX_COEFS);
    localparam int COEF_CNT_W = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // iteration counts (last value of the step counter)
    localparam logic [5:0] SQRT_LAST = 6'd31;
    localparam logic [5:0] CORD_LAST = 6'd29;
    localparam logic [5:0] DIV_LAST  = 6'd30;
    localparam logic [5:0] MUL_LAST  = 6'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_U  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_V  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AFFINE_C  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AFFINE_D  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AFFINE_E  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_CNT  = 3'd5;

    // word modes
    localparam logic MODE_PROJECT = 1'b0;
    localparam logic MODE_LOAD    = 1'b1;

    typedef struct packed {
        logic                mode;
        logic signed [31:0]  pos_x;
        logic signed [31:0]  pos_y;
        logic signed [31:0]  pos_z;
        logic [3:0]          coef_index;
        logic signed [47:0]  coef_value;
    } ocp_in_t;

    typedef struct packed {
        logic signed [31:0]  pixel_u;
        logic signed [31:0]  pixel_v;
        logic                valid_res;
    } ocp_out_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQX, ST_SQY, ST_SQSUM, ST_SQRT, ST_CINIT, ST_CORD, ST_THETA,
        ST_HCHK, ST_HMUL, ST_HADD, ST_DINX, ST_DIVX, ST_DINY, ST_DIVY,
        ST_MULU, ST_MULV, ST_MULC, ST_MULD, ST_MULE, ST_FIN
    } ocp_state_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_COEF, OP_LOAD, OP_SQX, OP_SQY, OP_SQSUM, OP_SQRT, OP_CINIT,
        OP_CORD, OP_THETA, OP_MULH, OP_HADD, OP_DINX, OP_DIVX, OP_DINY, OP_DIVY,
        OP_MULU, OP_MULV, OP_MULC, OP_MULD, OP_MULE, OP_OUT
    } ocp_op_t;

    typedef struct packed {
        ocp_op_t op;
    } ocp_cmd_t;

    typedef struct packed {
        logic in_mode;
        logic z_neg;
        logic r_zero;
        logic horn_more;
        logic last;
    } ocp_stat_t;

    // CORDIC angle step atan(2^-i) in Q1.30
    function automatic logic [30:0] atan_step(input logic [4:0] i);
        logic [30:0] s;
        case (i)
            5'd0: s = 31'd843314857;
            5'd1: s = 31'd497837830;
            5'd2: s = 31'd263043837;
            5'd3: s = 31'd133525159;
            5'd4: s = 31'd67021687;
            5'd5: s = 31'd33543515;
            5'd6: s = 31'd16775852;
            5'd7: s = 31'd8388438;
            5'd8: s = 31'd4194283;
            5'd9: s = 31'd2097149;
            default: s = 31'd1 << (5'd30 - i);
        endcase
        return s;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        logic signed [47:0] r;
        if (v > 49'sh0_7FFF_FFFF_FFFF)
            r = 48'sh7FFF_FFFF_FFFF;
        else if (v < -49'sh0_8000_0000_0000)
            r = 48'sh8000_0000_0000;
        else
            r = v[47:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -50'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// File: rtl/ocp_ctrl.sv
// ============================================================================
// ocp_ctrl
// Sequencer: steps the datapath through one projection or coefficient load, owns the handshakes.
// ============================================================================
module ocp_ctrl
    import ocp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  ocp_stat_t stat,
    output ocp_cmd_t  cmd
);

    ocp_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd.op       = OP_NOP;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (stat.in_mode == MODE_LOAD) begin
                        cmd.op = OP_COEF;
                    end else begin
                        cmd.op     = OP_LOAD;
                        state_next = ST_SQX;
                    end
                end
            end
            ST_SQX: begin
                cmd.op     = OP_SQX;
                state_next = stat.z_neg ? ST_FIN : ST_SQY;
            end
            ST_SQY: begin
                cmd.op     = OP_SQY;
                state_next = ST_SQSUM;
            end
            ST_SQSUM: begin
                cmd.op     = OP_SQSUM;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.op = OP_SQRT;
                if (stat.last) state_next = ST_CINIT;
            end
            ST_CINIT: begin
                // on the axis the pixel is the centre
                cmd.op     = OP_CINIT;
                state_next = stat.r_zero ? ST_MULC : ST_CORD;
            end
            ST_CORD: begin
                cmd.op = OP_CORD;
                if (stat.last) state_next = ST_THETA;
            end
            ST_THETA: begin
                cmd.op     = OP_THETA;
                state_next = ST_HCHK;
            end
            ST_HCHK: begin
                state_next = stat.horn_more ? ST_HMUL : ST_DINX;
            end
            ST_HMUL: begin
                cmd.op = OP_MULH;
                if (stat.last) state_next = ST_HADD;
            end
            ST_HADD: begin
                cmd.op     = OP_HADD;
                state_next = ST_HCHK;
            end
            ST_DINX: begin
                cmd.op     = OP_DINX;
                state_next = ST_DIVX;
            end
            ST_DIVX: begin
                cmd.op = OP_DIVX;
                if (stat.last) state_next = ST_DINY;
            end
            ST_DINY: begin
                cmd.op     = OP_DINY;
                state_next = ST_DIVY;
            end
            ST_DIVY: begin
                cmd.op = OP_DIVY;
                if (stat.last) state_next = ST_MULU;
            end
            ST_MULU: begin
                cmd.op = OP_MULU;
                if (stat.last) state_next = ST_MULV;
            end
            ST_MULV: begin
                cmd.op = OP_MULV;
                if (stat.last) state_next = ST_MULC;
            end
            ST_MULC: begin
                cmd.op = OP_MULC;
                if (stat.last) state_next = ST_MULD;
            end
            ST_MULD: begin
                cmd.op = OP_MULD;
                if (stat.last) state_next = ST_MULE;
            end
            ST_MULE: begin
                cmd.op = OP_MULE;
                if (stat.last) state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = OP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

// File: rtl/ocp_dp.sv
// ============================================================================
// ocp_dp
// Datapath: registers, coefficient table, shared 32x32 multiplier, square
// root, CORDIC, divider and the output word.
// ============================================================================
module ocp_dp
    import ocp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  ocp_in_t               s_data,
    input  ocp_cmd_t              cmd,
    output ocp_stat_t             stat,
    output ocp_out_t              m_data
);

    // configuration
    logic [27:0]           center_u_reg, center_v_reg;
    logic signed [31:0]    affine_c_reg, affine_d_reg, affine_e_reg;
    logic [COEF_CNT_W-1:0] coef_count_reg;
    logic signed [47:0]    coef_table_reg [MAX_COEFS];

    // point and working registers
    logic signed [31:0] x_reg, y_reg;
    logic               z_neg_reg;
    logic signed [35:0] cx_reg, cy_reg;
    logic signed [32:0] ang_reg;
    logic [5:0]         cnt_reg;
    logic [63:0]        mulp_reg, sumsq_reg, sqn_reg;
    logic [35:0]        srem_reg;
    logic [31:0]        root_reg;
    logic [95:0]        acc_reg;
    logic signed [47:0] mres_reg, rho_reg, theta_reg;
    logic [COEF_IDX_W-1:0] k_reg;
    logic [62:0]        num_reg;
    logic [31:0]        drem_reg;
    logic [30:0]        q_reg;
    logic signed [31:0] rx_reg, ry_reg;
    logic signed [47:0] u16_reg, v16_reg, pc_reg, pd_reg, pe_reg;
    ocp_out_t           out_reg;

    logic [31:0] mx, my;
    assign mx = x_reg[31] ? 32'd0 - 32'(x_reg) : 32'(x_reg);
    assign my = y_reg[31] ? 32'd0 - 32'(y_reg) : 32'(y_reg);

    // ---- step counter ----
    logic is_mul, cnt_last;
    always_comb begin
        is_mul = (cmd.op == OP_MULH) || (cmd.op == OP_MULU) || (cmd.op == OP_MULV) ||
                 (cmd.op == OP_MULC) || (cmd.op == OP_MULD) || (cmd.op == OP_MULE);
        case (cmd.op)
            OP_SQRT: cnt_last = (cnt_reg == SQRT_LAST);
            OP_CORD: cnt_last = (cnt_reg == CORD_LAST);
            OP_DIVX, OP_DIVY: cnt_last = (cnt_reg == DIV_LAST);
            default: cnt_last = is_mul && (cnt_reg == MUL_LAST);
        endcase
    end

    logic iterating;
    assign iterating = is_mul || (cmd.op == OP_SQRT) || (cmd.op == OP_CORD) ||
                       (cmd.op == OP_DIVX) || (cmd.op == OP_DIVY);

    // ---- rounding multiplier operands ----
    logic signed [47:0] opa, opb;
    logic [5:0]         sh;
    always_comb begin
        opa = '0;
        opb = '0;
        sh  = 6'd24;
        case (cmd.op)
            OP_MULH: begin opa = rho_reg; opb = theta_reg; sh = 6'd24; end
            OP_MULU: begin opa = 48'(rx_reg); opb = rho_reg; sh = 6'd38; end
            OP_MULV: begin opa = 48'(ry_reg); opb = rho_reg; sh = 6'd38; end
            OP_MULC: begin opa = 48'(affine_c_reg); opb = u16_reg; sh = 6'd30; end
            OP_MULD: begin opa = 48'(affine_d_reg); opb = v16_reg; sh = 6'd30; end
            OP_MULE: begin opa = 48'(affine_e_reg); opb = u16_reg; sh = 6'd30; end
            default: begin opa = '0; opb = '0; sh = 6'd24; end
        endcase
    end

    logic        neg;
    logic [47:0] ma, mb;
    assign neg = opa[47] ^ opb[47];
    assign ma  = opa[47] ? 48'd0 - 48'(opa) : 48'(opa);
    assign mb  = opb[47] ? 48'd0 - 48'(opb) : 48'(opb);

    // shared multiplier: squares, then four partial products per product
    logic [31:0] mul_a, mul_b;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.op == OP_SQX) begin
            mul_a = mx; mul_b = mx;
        end else if (cmd.op == OP_SQY) begin
            mul_a = my; mul_b = my;
        end else if (is_mul) begin
            case (cnt_reg)
                6'd0: begin mul_a = ma[31:0]; mul_b = mb[31:0]; end
                6'd1: begin mul_a = ma[31:0]; mul_b = 32'(mb[47:32]); end
                6'd2: begin mul_a = 32'(ma[47:32]); mul_b = mb[31:0]; end
                6'd3: begin mul_a = 32'(ma[47:32]); mul_b = 32'(mb[47:32]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    logic [95:0] pp_sh;
    always_comb begin
        case (cnt_reg)
            6'd1:       pp_sh = 96'(mulp_reg);
            6'd2, 6'd3: pp_sh = 96'(mulp_reg) << 32;
            6'd4:       pp_sh = 96'(mulp_reg) << 64;
            default:    pp_sh = '0;
        endcase
    end

    // round half away from zero, saturate to 48 bit
    logic [96:0]        rsum, rq;
    logic [47:0]        lim, rmag;
    logic signed [47:0] mres;
    always_comb begin
        rsum = {1'b0, acc_reg} + (97'd1 << (sh - 6'd1));
        rq   = rsum >> sh;
        lim  = 48'h8000_0000_0000 - {47'd0, !neg};
        rmag = (rq > 97'(lim)) ? lim : rq[47:0];
        mres = neg ? 48'd0 - rmag : rmag;
    end

    // ---- square root step ----
    logic [35:0] srem2, strial;
    assign srem2  = {srem_reg[33:0], sqn_reg[63:62]};
    assign strial = {2'b00, root_reg, 2'b01};

    // ---- CORDIC step ----
    logic [4:0]         ci;
    logic signed [35:0] cdx, cdy;
    logic signed [32:0] cstep;
    assign ci    = cnt_reg[4:0];
    assign cdx   = cy_reg >>> ci;
    assign cdy   = cx_reg >>> ci;
    assign cstep = 33'(atan_step(ci));

    // ---- theta and Horner start ----
    logic [30:0]           ang_cl;
    logic [31:0]           ang_rnd;
    logic [COEF_CNT_W-1:0] n_use;
    always_comb begin
        if (ang_reg < 0)
            ang_cl = '0;
        else if (ang_reg > 33'(HALF_PI_Q30))
            ang_cl = HALF_PI_Q30;
        else
            ang_cl = ang_reg[30:0];
        ang_rnd = (32'(ang_cl) + 32'd32) >> 6;
        n_use = (coef_count_reg > COEF_CNT_W'(MAX_COEFS)) ?
                COEF_CNT_W'(MAX_COEFS) : coef_count_reg;
    end

    logic [COEF_IDX_W-1:0] km1;
    assign km1 = k_reg - 1'b1;

    // ---- divider step ----
    logic [4:0]  di;
    logic [32:0] drem2;
    logic        dbit;
    logic [31:0] dq;
    assign di    = 5'd30 - cnt_reg[4:0];
    assign drem2 = {drem_reg, num_reg[di]};
    assign dbit  = (drem2 >= 33'(root_reg));
    assign dq    = {q_reg, dbit};

    // ---- final sums ----
    logic signed [49:0] col, row;
    assign col = 50'(pc_reg) + 50'(pd_reg) + $signed({22'd0, center_u_reg});
    assign row = 50'(pe_reg) + 50'(v16_reg) + $signed({22'd0, center_v_reg});

    // ---- configuration and table ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_u_reg   <= '0;
            center_v_reg   <= '0;
            affine_c_reg   <= 32'sh4000_0000;
            affine_d_reg   <= '0;
            affine_e_reg   <= '0;
            coef_count_reg <= COEF_CNT_W'(1);
            for (int i = 0; i < MAX_COEFS; i++) coef_table_reg[i] <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_CENTER_U: center_u_reg   <= cfg_wdata[27:0];
                    CFG_CENTER_V: center_v_reg   <= cfg_wdata[27:0];
                    CFG_AFFINE_C: affine_c_reg   <= $signed(cfg_wdata);
                    CFG_AFFINE_D: affine_d_reg   <= $signed(cfg_wdata);
                    CFG_AFFINE_E: affine_e_reg   <= $signed(cfg_wdata);
                    CFG_COEF_CNT: coef_count_reg <= cfg_wdata[COEF_CNT_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.op == OP_COEF && 32'(s_data.coef_index) < 32'(MAX_COEFS))
                coef_table_reg[COEF_IDX_W'(s_data.coef_index)] <= s_data.coef_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            cnt_reg <= '0;
        else if (!iterating || cnt_last)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_reg + 6'd1;
    end

    // ---- datapath registers ----
    always_ff @(posedge aclk) begin
        mulp_reg <= 64'(mul_a) * 64'(mul_b);
        if (is_mul && cnt_reg >= 6'd1 && cnt_reg <= 6'd4)
            acc_reg <= ((cnt_reg == 6'd1) ? 96'd0 : acc_reg) + pp_sh;
        case (cmd.op)
            OP_LOAD: begin
                x_reg     <= s_data.pos_x;
                y_reg     <= s_data.pos_y;
                z_neg_reg <= s_data.pos_z[31];
                cy_reg    <= 36'(s_data.pos_z);
                u16_reg   <= '0;
                v16_reg   <= '0;
            end
            OP_SQY: sumsq_reg <= mulp_reg;
            OP_SQSUM: begin
                sqn_reg  <= sumsq_reg + mulp_reg;
                srem_reg <= '0;
                root_reg <= '0;
            end
            OP_SQRT: begin
                sqn_reg <= sqn_reg << 2;
                if (srem2 >= strial) begin
                    srem_reg <= srem2 - strial;
                    root_reg <= {root_reg[30:0], 1'b1};
                end else begin
                    srem_reg <= srem2;
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
            OP_CINIT: begin
                cx_reg  <= $signed({4'd0, root_reg});
                ang_reg <= '0;
            end
            OP_CORD: begin
                if (cy_reg >= 0) begin
                    cx_reg  <= cx_reg + cdx;
                    cy_reg  <= cy_reg - cdy;
                    ang_reg <= ang_reg + cstep;
                end else begin
                    cx_reg  <= cx_reg - cdx;
                    cy_reg  <= cy_reg + cdy;
                    ang_reg <= ang_reg - cstep;
                end
            end
            OP_THETA: begin
                theta_reg <= 48'sd0 - $signed({16'd0, ang_rnd});
                if (n_use == '0) begin
                    rho_reg <= '0;
                    k_reg   <= '0;
                end else begin
                    rho_reg <= coef_table_reg[COEF_IDX_W'(n_use - 1'b1)];
                    k_reg   <= COEF_IDX_W'(n_use - 1'b1);
                end
            end
            OP_HADD: begin
                rho_reg <= sat48(49'(mres_reg) + 49'(coef_table_reg[km1]));
                k_reg   <= km1;
            end
            OP_DINX, OP_DINY: begin
                num_reg  <= ({31'd0, (cmd.op == OP_DINX) ? mx : my} << 30)
                            + 63'(root_reg >> 1);
                drem_reg <= 32'(({31'd0, (cmd.op == OP_DINX) ? mx : my} << 30)
                            + 63'(root_reg >> 1) >> 31);
                q_reg    <= '0;
            end
            OP_DIVX, OP_DIVY: begin
                drem_reg <= dbit ? 32'(drem2 - 33'(root_reg)) : drem2[31:0];
                q_reg    <= dq[30:0];
                if (cnt_last) begin
                    if (cmd.op == OP_DIVX)
                        rx_reg <= x_reg[31] ? 32'sd0 - $signed(dq) : $signed(dq);
                    else
                        ry_reg <= y_reg[31] ? 32'sd0 - $signed(dq) : $signed(dq);
                end
            end
            OP_OUT: begin
                if (z_neg_reg) begin
                    out_reg <= '0;
                end else begin
                    out_reg.pixel_u   <= sat32(col);
                    out_reg.pixel_v   <= sat32(row);
                    out_reg.valid_res <= 1'b1;
                end
            end
            default: ;
        endcase
        if (is_mul && cnt_last) begin
            mres_reg <= mres;
            case (cmd.op)
                OP_MULU: u16_reg <= mres;
                OP_MULV: v16_reg <= mres;
                OP_MULC: pc_reg  <= mres;
                OP_MULD: pd_reg  <= mres;
                OP_MULE: pe_reg  <= mres;
                default: ;
            endcase
        end
    end

    assign stat.in_mode   = s_data.mode;
    assign stat.z_neg     = z_neg_reg;
    assign stat.r_zero    = (root_reg == '0);
    assign stat.horn_more = (k_reg != '0);
    assign stat.last      = cnt_last;
    assign m_data         = out_reg;

endmodule

// File: rtl/omnidirectional_camera_projection.sv
// ============================================================================
// omnidirectional_camera_projection
// Polynomial fisheye projection of a camera-frame point onto the image.
// ============================================================================
//  channel   dir   handshake           word
//  s_        in    s_valid / s_ready   ocp_in_t  (point or coefficient load)
//  m_        out   m_valid / m_ready   ocp_out_t (pixel, valid_res)
//  cfg_      in    cfg_wr_en           cfg_index, cfg_wdata
//
//  Coefficient loads give no word and leave the sequencer idle.
//  A point runs 32 square-root steps, 30 CORDIC steps, n-1 Horner steps (n =
//  coef_count capped at 16, zero counts as one), two 31-step divisions and
//  products on the one shared 32x32 multiplier (four partial products, a
//  rounding step); each Horner step adds a product, the table add and a check.
//  A point on the axis skips from the square root to the affine products.
//  Points behind the camera go from the first squaring straight to the output.
//  aresetn is synchronous, active low; it clears the sequencer, configuration
//  registers and coefficient table. A result held by m_ready low stalls only the
//  final write; the next word is accepted as soon as the sequencer is idle.
// ============================================================================
module omnidirectional_camera_projection
    import ocp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ocp_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ocp_out_t              m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    ocp_cmd_t  cmd;
    ocp_stat_t stat;

    // sequencer
    ocp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // arithmetic, table and output register
    ocp_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_data    (m_data)
    );

`ifndef NO_ASSERTIONS
    // a point keeps the block busy
    a_point_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.mode == MODE_PROJECT |=> !s_ready)
        else $error("point accepted but block still ready");

    // a coefficient load never stalls the input
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.mode == MODE_LOAD |=> s_ready)
        else $error("coefficient load stalled the input");

    // a point behind the camera gives a zero pixel
    a_behind_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.valid_res |-> m_data.pixel_u == 0 && m_data.pixel_v == 0)
        else $error("invalid word with non-zero pixel");
`endif

endmodule
